@@ src/psh_pkg.sv @@
// psh_pkg: shared types, constants and helper functions for the program stream
// header generator (front, queue, back and top level).
// no dependencies
package psh_pkg;

    localparam int HDR_MAX_BYTES = 19;
    localparam int HDR_BITS      = HDR_MAX_BYTES * 8;
    localparam int CNT_W         = $clog2(HDR_MAX_BYTES + 1);

    // request codes
    localparam logic [1:0] CMD_PACK   = 2'd0;
    localparam logic [1:0] CMD_SYSTEM = 2'd1;
    localparam logic [1:0] CMD_PES    = 2'd2;

    // register indexes on the apb port
    localparam int          REG_IDX_W          = 3;
    localparam logic [2:0]  REG_MUX_RATE       = 3'd0;
    localparam logic [2:0]  REG_VIDEO_ID       = 3'd1;
    localparam logic [2:0]  REG_VIDEO_SCALE    = 3'd2;
    localparam logic [2:0]  REG_VIDEO_SIZE     = 3'd3;
    localparam logic [2:0]  REG_AUDIO_ID       = 3'd4;
    localparam logic [2:0]  REG_AUDIO_SCALE    = 3'd5;
    localparam logic [2:0]  REG_AUDIO_SIZE     = 3'd6;
    localparam int          ADDR_W             = 5;

    localparam logic [21:0] MUX_RATE_RST    = 22'd384253;
    localparam logic [7:0]  VIDEO_ID_RST    = 8'd224;
    localparam logic        VIDEO_SCALE_RST = 1'b1;
    localparam logic [12:0] VIDEO_SIZE_RST  = 13'd4096;
    localparam logic [7:0]  AUDIO_ID_RST    = 8'd189;
    localparam logic        AUDIO_SCALE_RST = 1'b0;
    localparam logic [12:0] AUDIO_SIZE_RST  = 13'd58;

    localparam logic [31:0] PACK_START   = 32'h0000_01BA;
    localparam logic [31:0] SYSTEM_START = 32'h0000_01BB;
    localparam logic [23:0] PES_PREFIX   = 24'h00_0001;
    localparam logic [4:0]  RSVD_ONES    = 5'd31;
    localparam logic [6:0]  RSVD_SEVEN   = 7'd127;

    // scr split: base = time / 300, ext = time % 300, radix-8 long division
    localparam int          SCR_DIV      = 300;
    localparam int          TIME_W       = 42;
    localparam int          DIGIT_W      = 3;
    localparam int          DIV_STEPS    = TIME_W / DIGIT_W;
    localparam int          STEP_W       = $clog2(DIV_STEPS);
    localparam int          REM_W        = 9;
    localparam int          PART_W       = REM_W + DIGIT_W;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [41:0] clock_time;
        logic [7:0]  stream_number;
        logic [15:0] pes_length;
        logic [32:0] pts_value;
        logic        pts_present;
        logic [32:0] dts_value;
        logic        dts_present;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_t;

    typedef struct packed {
        logic [21:0] mux_rate;
        logic [7:0]  video_stream_id;
        logic        video_buffer_scale;
        logic [12:0] video_buffer_size;
        logic [7:0]  audio_stream_id;
        logic        audio_buffer_scale;
        logic [12:0] audio_buffer_size;
    } cfg_t;

    // one finished header, byte 0 in the top bits
    typedef struct packed {
        logic [HDR_BITS-1:0] bytes;
        logic [CNT_W-1:0]    n;
    } hdr_t;

    // one radix-8 division step: returns {digit, new remainder}
    function automatic logic [DIGIT_W+REM_W-1:0] div_step(
        input logic [REM_W-1:0]   rem,
        input logic [DIGIT_W-1:0] bits
    );
        logic [PART_W-1:0]  x;
        logic [DIGIT_W-1:0] d;
        logic [PART_W-1:0]  r;
        x = {rem, bits};
        d = '0;
        for (int k = 1; k < (1 << DIGIT_W); k++) begin
            if (x >= PART_W'(k * SCR_DIV))
                d = DIGIT_W'(k);
        end
        r = x - PART_W'(PART_W'(d) * PART_W'(SCR_DIV));
        return {d, r[REM_W-1:0]};
    endfunction

    // 40-bit pts / dts field with marker bits
    function automatic logic [39:0] stamp(
        input logic [3:0]  prefix,
        input logic [32:0] t
    );
        return {prefix, t[32:30], 1'b1, t[29:15], 1'b1, t[14:0], 1'b1};
    endfunction

endpackage

@@ src/psh_front.sv @@
// psh_front: accepts header requests, splits the clock reference for pack headers
// and assembles the header bytes for the queue. uses psh_pkg.
module psh_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  psh_pkg::in_t  in_data,
    input  psh_pkg::cfg_t cfg,
    output logic          push_valid,
    input  logic          push_ready,
    output psh_pkg::hdr_t push_data
);
    import psh_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]          state_reg, state_next;
    in_t                 item_reg;
    logic [TIME_W-1:0]   quot_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DIGIT_W+REM_W-1:0] step_res;
    logic                accept;

    logic [32:0]         base;
    logic [15:0]         sys_len;
    logic [23:0]         v_entry, a_entry, e0, e1;
    logic                v_on, a_on, pts, dts;
    logic [1:0]          flags;
    logic [7:0]          hlen;

    assign in_ready   = (state_reg == ST_IDLE) || ((state_reg == ST_PUSH) && push_ready);
    assign accept     = in_valid && in_ready;
    assign push_valid = (state_reg == ST_PUSH);
    assign step_res   = div_step(rem_reg, quot_reg[TIME_W-1 -: DIGIT_W]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (push_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = state_reg;
        endcase
        if (accept)
        begin
            unique case (in_data.cmd)
                CMD_PACK:            state_next = ST_DIV;
                CMD_SYSTEM, CMD_PES: state_next = ST_PUSH;
                default:             state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            quot_reg <= in_data.clock_time;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            // quotient digits shift in from the bottom as time bits leave the top
            quot_reg <= {quot_reg[TIME_W-DIGIT_W-1:0], step_res[DIGIT_W+REM_W-1 -: DIGIT_W]};
            rem_reg  <= step_res[REM_W-1:0];
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // header assembly
    always_comb
    begin
        base    = quot_reg[32:0];
        v_on    = (cfg.video_stream_id != 8'd0);
        a_on    = (cfg.audio_stream_id != 8'd0);
        v_entry = {cfg.video_stream_id, 2'b11, cfg.video_buffer_scale, cfg.video_buffer_size};
        a_entry = {cfg.audio_stream_id, 2'b11, cfg.audio_buffer_scale, cfg.audio_buffer_size};
        e0      = v_on ? v_entry : a_entry;
        e1      = (v_on && a_on) ? a_entry : 24'd0;
        sys_len = 16'd6 + (v_on ? 16'd3 : 16'd0) + (a_on ? 16'd3 : 16'd0);
        pts     = item_reg.pts_present;
        dts     = pts && item_reg.dts_present;
        flags   = dts ? 2'd3 : (pts ? 2'd2 : 2'd0);
        hlen    = dts ? 8'd10 : (pts ? 8'd5 : 8'd0);
        push_data = '0;
        unique case (item_reg.cmd)
            CMD_PACK:
            begin
                push_data.bytes = {PACK_START, 2'b01, base[32:30], 1'b1, base[29:15], 1'b1,
                                   base[14:0], 1'b1, rem_reg, 1'b1, cfg.mux_rate, 1'b1, 1'b1,
                                   RSVD_ONES, 3'b000, 40'd0};
                push_data.n     = CNT_W'(14);
            end
            CMD_SYSTEM:
            begin
                push_data.bytes = {SYSTEM_START, sys_len, 1'b1, cfg.mux_rate, 1'b1, 6'd1,
                                   1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 5'd1, 1'b0, RSVD_SEVEN,
                                   e0, e1, 8'd0};
                push_data.n     = CNT_W'(12) + (v_on ? CNT_W'(3) : '0)
                                  + (a_on ? CNT_W'(3) : '0);
            end
            default:
            begin
                push_data.bytes = {PES_PREFIX, item_reg.stream_number, item_reg.pes_length,
                                   2'b10, 2'b00, 1'b1, 1'b0, 1'b0, 1'b0, flags, 6'd0, hlen,
                                   dts ? stamp(4'd3, item_reg.pts_value)
                                       : (pts ? stamp(4'd2, item_reg.pts_value) : 40'd0),
                                   dts ? stamp(4'd1, item_reg.dts_value) : 40'd0};
                push_data.n     = dts ? CNT_W'(19) : (pts ? CNT_W'(14) : CNT_W'(9));
            end
        endcase
    end

endmodule

@@ src/psh_queue.sv @@
// psh_queue: two-entry queue of assembled headers between front and back.
// uses psh_pkg.
module psh_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  psh_pkg::hdr_t push_data,
    output logic          pop_valid,
    input  logic          pop,
    output psh_pkg::hdr_t pop_data
);
    import psh_pkg::*;

    hdr_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + (do_push ? 2'd1 : 2'd0) - (do_pop ? 2'd1 : 2'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ src/psh_back.sv @@
// psh_back: serializes queued headers one byte per beat into the output register.
// uses psh_pkg.
module psh_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop,
    input  psh_pkg::hdr_t pop_data,
    output logic          out_valid,
    input  logic          out_ready,
    output psh_pkg::out_t out_data
);
    import psh_pkg::*;

    logic [HDR_BITS-1:0] cur_reg;
    logic [CNT_W-1:0]    left_reg;
    logic                out_valid_reg;
    out_t                out_reg;
    logic [HDR_BITS-1:0] src_bytes;
    logic [CNT_W-1:0]    src_n;
    logic                src_ok, advance;

    // first byte of a header comes straight from the queue head
    assign src_bytes = (left_reg != '0) ? cur_reg : pop_data.bytes;
    assign src_n     = (left_reg != '0) ? left_reg : pop_data.n;
    assign src_ok    = (left_reg != '0) || pop_valid;
    assign advance   = src_ok && (!out_valid_reg || out_ready);
    assign pop       = advance && (left_reg == '0);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= src_n - CNT_W'(1);
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg.out_byte  <= src_bytes[HDR_BITS-1 -: 8];
            out_reg.last_byte <= (src_n == CNT_W'(1));
            cur_reg           <= {src_bytes[HDR_BITS-9:0], 8'd0};
        end
    end

endmodule

@@ src/program_stream_header_generator_unit.sv @@
// program_stream_header_generator_unit: top level with apb registers, front,
// header queue and byte back end. uses psh_pkg, psh_front, psh_queue, psh_back.
//
//  channel   signals                      beat
//  in        in_valid / in_ready          one header request (in_t)
//  out       out_valid / out_ready        one header byte with last flag (out_t)
//  apb       psel penable pwrite paddr    one 32-bit register access
//
// each header leaves at one byte per cycle while out_ready is high, set by the single
// output byte register: 14 bytes (pack), 12 to 18 (system), 9, 14 or 19 (pes) per request.
// a pack request runs the front's radix-8 divider and then hands its header over, overlapping
// the back end; the front takes the next request only as it pushes the finished header.
// reset loads the register defaults; no clearing pass, requests taken at once.
// out_ready low holds the current byte; the queue absorbs two finished headers.
module program_stream_header_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  psh_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output psh_pkg::out_t                 out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psh_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import psh_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 push_valid, push_ready, pop_valid, pop;
    hdr_t                 push_data, pop_data;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mux_rate           <= MUX_RATE_RST;
            cfg_reg.video_stream_id    <= VIDEO_ID_RST;
            cfg_reg.video_buffer_scale <= VIDEO_SCALE_RST;
            cfg_reg.video_buffer_size  <= VIDEO_SIZE_RST;
            cfg_reg.audio_stream_id    <= AUDIO_ID_RST;
            cfg_reg.audio_buffer_scale <= AUDIO_SCALE_RST;
            cfg_reg.audio_buffer_size  <= AUDIO_SIZE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MUX_RATE:    cfg_reg.mux_rate           <= pwdata[21:0];
                REG_VIDEO_ID:    cfg_reg.video_stream_id    <= pwdata[7:0];
                REG_VIDEO_SCALE: cfg_reg.video_buffer_scale <= pwdata[0];
                REG_VIDEO_SIZE:  cfg_reg.video_buffer_size  <= pwdata[12:0];
                REG_AUDIO_ID:    cfg_reg.audio_stream_id    <= pwdata[7:0];
                REG_AUDIO_SCALE: cfg_reg.audio_buffer_scale <= pwdata[0];
                REG_AUDIO_SIZE:  cfg_reg.audio_buffer_size  <= pwdata[12:0];
                default:         cfg_reg.mux_rate           <= cfg_reg.mux_rate;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MUX_RATE:    prdata = {10'd0, cfg_reg.mux_rate};
            REG_VIDEO_ID:    prdata = {24'd0, cfg_reg.video_stream_id};
            REG_VIDEO_SCALE: prdata = {31'd0, cfg_reg.video_buffer_scale};
            REG_VIDEO_SIZE:  prdata = {19'd0, cfg_reg.video_buffer_size};
            REG_AUDIO_ID:    prdata = {24'd0, cfg_reg.audio_stream_id};
            REG_AUDIO_SCALE: prdata = {31'd0, cfg_reg.audio_buffer_scale};
            REG_AUDIO_SIZE:  prdata = {19'd0, cfg_reg.audio_buffer_size};
            default:         prdata = 32'd0;
        endcase
    end

    psh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    psh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    psh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // a pack request keeps the front busy while the divider runs
    a_pack_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.cmd == CMD_PACK) |=> !in_ready)
        else $error("front took a request during division");

    // a mux rate write lands in the register
    a_mux_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && (reg_idx == REG_MUX_RATE) |=> cfg_reg.mux_rate == $past(pwdata[21:0]))
        else $error("mux rate write lost");

    // a queue pop only happens when the back end has an output slot
    a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        pop && pop_valid |=> out_valid)
        else $error("header popped without a byte being shown");

endmodule
